### rtl/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (b)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (b)) \
    else $error("assertion failed");

`endif

### rtl/aesb_pkg.sv
// Types, tables and round functions of the AES-128 block engine
package aesb_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned RkIdxW    = $clog2(NumRounds + 1);

  typedef enum logic [2:0] {
    REG_KEY_HIGH  = 3'd0,
    REG_KEY_LOW   = 3'd1,
    REG_IV_HIGH   = 3'd2,
    REG_IV_LOW    = 3'd3,
    REG_ENCRYPT   = 3'd4,
    REG_CHAIN     = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [127:0] blk;
    logic         start;
  } item_t;

  typedef struct packed {
    logic         encrypt;
    logic         cbc;
    logic [127:0] iv;
  } mode_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
    8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
    8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
    8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
    8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
    8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
    8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
    8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
    8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
    8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
    8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
    8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
    8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
    8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
    8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
    8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
    8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
    8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
    8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
    8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
    8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
    8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
    8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
    8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
    8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
    8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
    8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
    8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
    8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
    8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
    8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
    8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
  };

  localparam logic [7:0] RCON [NumRounds] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  function automatic logic [7:0] xt(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] get_b(logic [127:0] s, int unsigned i);
    return s[127 - 8 * i -: 8];
  endfunction

  // one expansion step: next round key from the previous one
  function automatic logic [127:0] key_next(logic [127:0] k, logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    t  = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  function automatic logic [127:0] enc_round(logic [127:0] s, logic last);
    logic [127:0] t, o;
    logic [7:0]   a0, a1, a2, a3;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        t[127 - 8 * (r + 4 * c) -: 8] = SBOX[get_b(s, r + 4 * ((c + r) % 4))];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = get_b(t, 4 * c);
      a1 = get_b(t, 4 * c + 1);
      a2 = get_b(t, 4 * c + 2);
      a3 = get_b(t, 4 * c + 3);
      o[127 - 32 * c -: 8]  = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
      o[119 - 32 * c -: 8]  = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
      o[111 - 32 * c -: 8]  = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
      o[103 - 32 * c -: 8]  = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
    end
    return last ? t : o;
  endfunction

  function automatic logic [7:0] gm(logic [7:0] a, logic [3:0] m);
    logic [7:0] x2, x4, x8;
    x2 = xt(a);
    x4 = xt(x2);
    x8 = xt(x4);
    return (m[0] ? a : 8'h00) ^ (m[1] ? x2 : 8'h00) ^ (m[2] ? x4 : 8'h00) ^
           (m[3] ? x8 : 8'h00);
  endfunction

  function automatic logic [127:0] dec_round(logic [127:0] s, logic [127:0] rk,
                                             logic mix);
    logic [127:0] t, o;
    logic [7:0]   a0, a1, a2, a3;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        t[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8] = INV_SBOX[get_b(s, r + 4 * c)];
      end
    end
    t = t ^ rk;
    for (int c = 0; c < 4; c++) begin
      a0 = get_b(t, 4 * c);
      a1 = get_b(t, 4 * c + 1);
      a2 = get_b(t, 4 * c + 2);
      a3 = get_b(t, 4 * c + 3);
      o[127 - 32 * c -: 8] = gm(a0, 4'd14) ^ gm(a1, 4'd11) ^ gm(a2, 4'd13) ^ gm(a3, 4'd9);
      o[119 - 32 * c -: 8] = gm(a0, 4'd9) ^ gm(a1, 4'd14) ^ gm(a2, 4'd11) ^ gm(a3, 4'd13);
      o[111 - 32 * c -: 8] = gm(a0, 4'd13) ^ gm(a1, 4'd9) ^ gm(a2, 4'd14) ^ gm(a3, 4'd11);
      o[103 - 32 * c -: 8] = gm(a0, 4'd11) ^ gm(a1, 4'd13) ^ gm(a2, 4'd9) ^ gm(a3, 4'd14);
    end
    return mix ? o : t;
  endfunction

endpackage

### rtl/aesb_front.sv
// Front end: input acceptance and two-entry request queue
module aesb_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  aesb_pkg::item_t in_item_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output aesb_pkg::item_t pop_item_o
);
  import aesb_pkg::*;

  item_t      mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign pop_valid_o = (cnt_q != 2'd0);
  assign pop_item_o  = mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = pop_valid_o && pop_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= in_item_i;
  end

endmodule

### rtl/aesb_keysched.sv
// Round key expansion and round key store
module aesb_keysched (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        restart_i,
  input  logic [127:0]                key_i,
  input  logic [aesb_pkg::RkIdxW-1:0] rd_idx_i,
  output logic [127:0]                rk_o,
  output logic                        ready_o
);
  import aesb_pkg::*;

  logic [127:0]      rk_q [NumRounds + 1];
  logic [127:0]      run_q, run_d;
  logic [RkIdxW-1:0] cnt_q;
  logic              busy_q;

  assign rk_o    = rk_q[rd_idx_i];
  assign ready_o = !busy_q;

  always_comb begin
    if (cnt_q == '0) begin
      run_d = key_i;
    end else begin
      run_d = key_next(run_q, RCON[cnt_q - RkIdxW'(1)]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (restart_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + RkIdxW'(1);
      if (cnt_q == RkIdxW'(NumRounds)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q && !restart_i) begin
      rk_q[cnt_q] <= run_d;
      run_q       <= run_d;
    end
  end

endmodule

### rtl/aesb_core.sv
// Back end: iterative AES round unit with chaining and result register
module aesb_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  aesb_pkg::mode_t             mode_i,
  input  logic                        pop_valid_i,
  output logic                        pop_ready_o,
  input  aesb_pkg::item_t             pop_item_i,
  input  logic                        keys_ready_i,
  output logic [aesb_pkg::RkIdxW-1:0] rk_idx_o,
  input  logic [127:0]                rk_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [127:0]                out_data_o
);
  import aesb_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_WAIT = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [127:0]      s_q, s_d, cv_q, chain_q, out_q;
  logic [RkIdxW-1:0] rnd_q;
  logic              enc_q, cbc_q, out_valid_q;
  logic [127:0]      cv, round_out, fin;
  logic              last, out_free, load;

  assign out_free    = !out_valid_q || out_ready_i;
  assign pop_ready_o = (state_q == S_IDLE) && keys_ready_i;
  assign load        = pop_valid_i && pop_ready_o;
  assign cv          = pop_item_i.start ? mode_i.iv : chain_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    if (state_q == S_IDLE) begin
      rk_idx_o = mode_i.encrypt ? '0 : RkIdxW'(NumRounds);
    end else begin
      rk_idx_o = rnd_q;
    end
  end

  always_comb begin
    if (enc_q) begin
      round_out = enc_round(s_q, rnd_q == RkIdxW'(NumRounds)) ^ rk_i;
      last      = (rnd_q == RkIdxW'(NumRounds));
      fin       = round_out;
    end else begin
      round_out = dec_round(s_q, rk_i, rnd_q != '0);
      last      = (rnd_q == '0);
      fin       = cbc_q ? (round_out ^ cv_q) : round_out;
    end
  end

  always_comb begin
    state_d = state_q;
    s_d     = s_q;
    case (state_q)
      S_IDLE: begin
        if (load) begin
          state_d = S_RUN;
          if (mode_i.encrypt) begin
            s_d = pop_item_i.blk ^ (mode_i.cbc ? cv : 128'd0) ^ rk_i;
          end else begin
            s_d = pop_item_i.blk ^ rk_i;
          end
        end
      end
      S_RUN: begin
        s_d = round_out;
        if (last) begin
          s_d     = fin;
          state_d = out_free ? S_IDLE : S_WAIT;
        end
      end
      S_WAIT: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      chain_q     <= '0;
    end else begin
      state_q <= state_d;
      if (out_ready_i) out_valid_q <= 1'b0;
      if (load) begin
        chain_q <= (mode_i.cbc && !mode_i.encrypt) ? pop_item_i.blk : cv;
      end
      if ((state_q == S_RUN) && last) begin
        if (enc_q && cbc_q) chain_q <= fin;
        if (out_free) out_valid_q <= 1'b1;
      end
      if ((state_q == S_WAIT) && out_free) out_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q <= s_d;
    if (load) begin
      cv_q  <= cv;
      enc_q <= mode_i.encrypt;
      cbc_q <= mode_i.cbc;
      rnd_q <= mode_i.encrypt ? RkIdxW'(1) : RkIdxW'(NumRounds - 1);
    end else if (state_q == S_RUN) begin
      rnd_q <= enc_q ? rnd_q + RkIdxW'(1) : rnd_q - RkIdxW'(1);
    end
    if ((state_q == S_RUN) && last && out_free) out_q <= fin;
    if ((state_q == S_WAIT) && out_free) out_q <= s_q;
  end

endmodule

### rtl/aes128_cbc_ecb_block_engine.sv
// Top level of the AES-128 ECB/CBC block engine
//
// Input channel: in_valid_i/in_ready_o with block_high_i, block_low_i and
// message_start_i; a request is taken when valid and ready are both high.
// Output channel: out_valid_o/out_ready_i with result_high_o, result_low_o.
// Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
// cfg_ready_o is always high. Write only while the engine is idle.
// An accepted request passes from the input queue into the round unit and
// then through the ten rounds to the output register. The single round unit
// that the ten rounds share works on one block at a time; the next request
// starts as soon as the current result lands in the output register.
// A two-entry queue accepts requests while the round unit is busy.
// After reset and after each key write the round keys are expanded; requests
// queue but do not start meanwhile.
// When the receiver stalls the result is held in the output register and
// the next finished block waits in the round unit.
module aes128_cbc_ecb_block_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] block_high_i,
  input  logic [63:0] block_low_i,
  input  logic        message_start_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] result_high_o,
  output logic [63:0] result_low_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);
  import aesb_pkg::*;

  logic [63:0]       key_high_q, key_low_q, iv_high_q, iv_low_q;
  logic              encrypt_q, chain_q;
  logic              cfg_wr, restart;
  item_t             in_item, pop_item;
  logic              pop_valid, pop_ready, keys_ready;
  logic [RkIdxW-1:0] rk_idx;
  logic [127:0]      rk, out_data;
  mode_t             mode;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign restart     = cfg_wr && ((cfg_index_i == REG_KEY_HIGH) ||
                                  (cfg_index_i == REG_KEY_LOW));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
      iv_high_q  <= '0;
      iv_low_q   <= '0;
      encrypt_q  <= 1'b1;
      chain_q    <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_index_i)
        REG_KEY_HIGH: key_high_q <= cfg_data_i;
        REG_KEY_LOW:  key_low_q  <= cfg_data_i;
        REG_IV_HIGH:  iv_high_q  <= cfg_data_i;
        REG_IV_LOW:   iv_low_q   <= cfg_data_i;
        REG_ENCRYPT:  encrypt_q  <= cfg_data_i[0];
        REG_CHAIN:    chain_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign in_item.blk   = {block_high_i, block_low_i};
  assign in_item.start = message_start_i;
  assign mode.encrypt  = encrypt_q;
  assign mode.cbc      = chain_q;
  assign mode.iv       = {iv_high_q, iv_low_q};

  aesb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_item_o  (pop_item)
  );

  aesb_keysched u_keysched (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (restart),
    .key_i     ({key_high_q, key_low_q}),
    .rd_idx_i  (rk_idx),
    .rk_o      (rk),
    .ready_o   (keys_ready)
  );

  aesb_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mode_i       (mode),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_item_i   (pop_item),
    .keys_ready_i (keys_ready),
    .rk_idx_o     (rk_idx),
    .rk_i         (rk),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data)
  );

  assign result_high_o = out_data[127:64];
  assign result_low_o  = out_data[63:0];

endmodule

### rtl/aesb_checker.sv
// Port-level checker for the block engine, bound to the top level
`include "assert_macros.svh"

module aesb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [63:0] block_high_i,
  input logic [63:0] block_low_i,
  input logic        message_start_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [63:0] result_high_o,
  input logic [63:0] result_low_o,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic [2:0]  cfg_index_i,
  input logic [63:0] cfg_data_i
);

  `ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)
  `ASSERT_NXT(a_out_stable, out_valid_o && !out_ready_i,
              $stable(result_high_o) && $stable(result_low_o))
  `ASSERT_IMP(a_quiet_after_reset, !$past(rst_ni), !out_valid_o)
  `ASSERT_IMP(a_ready_after_reset, !$past(rst_ni), in_ready_o && cfg_ready_o)

endmodule

bind aes128_cbc_ecb_block_engine aesb_checker u_aesb_checker (.*);

### tb/tb.sv
// Self-checking testbench for the AES-128 ECB/CBC block engine
module tb;
  import aesb_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam logic [2:0] RegSpare = 3'd6;
  localparam logic [2:0] RegTop = 3'd7;
  localparam logic [63:0] Ones = '1;

  typedef enum logic {ROW_CFG, ROW_BLK} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [2:0]  idx;
    logic [63:0] hi;
    logic [63:0] lo;
    logic        start;
    logic        typed;
    logic [63:0] exp_hi;
    logic [63:0] exp_lo;
  } row_t;

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
  } block_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [63:0] block_high_i = '0;
  logic [63:0] block_low_i = '0;
  logic        message_start_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [63:0] result_high_o;
  logic [63:0] result_low_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;

  aes128_cbc_ecb_block_engine dut (.*);

  always #4 clk_i = ~clk_i;

  logic [7:0]   sub_tab [256];
  logic [7:0]   inv_tab [256];
  logic [127:0] round_keys [11];
  logic [63:0]  key_hi, key_lo, iv_hi, iv_lo, chain_hi, chain_lo;
  logic         enc_mode, cbc_mode;
  block_t       pending_results [$];
  row_t         plan [$];
  int unsigned  mismatches = 0;
  int unsigned  cycles = 0;
  int unsigned  hold_left = 0;
  int unsigned  blocks_sent = 0;
  int unsigned  results_seen = 0;
  bit           calm = 1'b0;

  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return r;
  endfunction

  function automatic logic [7:0] gf_inv(logic [7:0] x);
    logic [7:0] r, p;
    r = 8'h01;
    p = x;
    for (int i = 0; i < 7; i++) begin
      p = gf_mul(p, p);
      r = gf_mul(r, p);
    end
    return r;
  endfunction

  function automatic logic [127:0] expand_round(logic [127:0] k, logic [7:0] rc);
    logic [31:0] w [4];
    logic [31:0] t;
    for (int i = 0; i < 4; i++) w[i] = k[127 - 32 * i -: 32];
    t = {sub_tab[w[3][23:16]] ^ rc, sub_tab[w[3][15:8]], sub_tab[w[3][7:0]],
         sub_tab[w[3][31:24]]};
    w[0] ^= t;
    for (int i = 1; i < 4; i++) w[i] ^= w[i - 1];
    return {w[0], w[1], w[2], w[3]};
  endfunction

  function automatic void load_key();
    logic [7:0] rc;
    rc = 8'h01;
    round_keys[0] = {key_hi, key_lo};
    for (int r = 1; r <= 10; r++) begin
      round_keys[r] = expand_round(round_keys[r - 1], rc);
      rc = gf_mul(rc, 8'h02);
    end
  endfunction

  function automatic logic [127:0] sub_shift(logic [127:0] s, bit inv);
    logic [127:0] t;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        if (!inv) begin
          t[127 - 8 * (r + 4 * c) -: 8] = sub_tab[s[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8]];
        end else begin
          t[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8] = inv_tab[s[127 - 8 * (r + 4 * c) -: 8]];
        end
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] mix_cols(logic [127:0] s, bit inv);
    logic [7:0]   coef [4];
    logic [7:0]   acc;
    logic [127:0] o;
    if (inv) begin
      coef = '{8'd14, 8'd11, 8'd13, 8'd9};
    end else begin
      coef = '{8'd2, 8'd3, 8'd1, 8'd1};
    end
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        acc = '0;
        for (int j = 0; j < 4; j++) begin
          acc ^= gf_mul(s[127 - 8 * (4 * c + j) -: 8], coef[(j - i + 4) % 4]);
        end
        o[127 - 8 * (4 * c + i) -: 8] = acc;
      end
    end
    return o;
  endfunction

  function automatic logic [127:0] cipher(logic [127:0] s, bit dec);
    if (!dec) begin
      s ^= round_keys[0];
      for (int r = 1; r <= 10; r++) begin
        s = sub_shift(s, 1'b0);
        if (r < 10) s = mix_cols(s, 1'b0);
        s ^= round_keys[r];
      end
    end else begin
      s ^= round_keys[10];
      for (int r = 9; r >= 0; r--) begin
        s = sub_shift(s, 1'b1) ^ round_keys[r];
        if (r > 0) s = mix_cols(s, 1'b1);
      end
    end
    return s;
  endfunction

  function automatic block_t crypt_block(logic [63:0] hi, logic [63:0] lo, logic st);
    logic [127:0] v;
    block_t       o;
    if (st) begin
      chain_hi = iv_hi;
      chain_lo = iv_lo;
    end
    if (enc_mode) begin
      v = cbc_mode ? {hi ^ chain_hi, lo ^ chain_lo} : {hi, lo};
      v = cipher(v, 1'b0);
      if (cbc_mode) {chain_hi, chain_lo} = v;
    end else begin
      v = cipher({hi, lo}, 1'b1);
      if (cbc_mode) begin
        v ^= {chain_hi, chain_lo};
        chain_hi = hi;
        chain_lo = lo;
      end
    end
    o.hi = v[127:64];
    o.lo = v[63:0];
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch on %s: got %h, want %h (result %0d)", what, got, want, results_seen);
    mismatches++;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_KEY_HIGH: key_hi = data;
      REG_KEY_LOW:  key_lo = data;
      REG_IV_HIGH:  iv_hi = data;
      REG_IV_LOW:   iv_lo = data;
      REG_ENCRYPT:  enc_mode = data[0];
      REG_CHAIN:    cbc_mode = data[0];
      default: ;
    endcase
    load_key();
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic send_block(logic [63:0] hi, logic [63:0] lo, logic st, logic typed,
                            logic [63:0] ehi, logic [63:0] elo);
    block_t b;
    in_valid_i = 1'b1;
    block_high_i = hi;
    block_low_i = lo;
    message_start_i = st;
    do @(posedge clk_i); while (!in_ready_o);
    b = crypt_block(hi, lo, st);
    if (typed) begin
      b.hi = ehi;
      b.lo = elo;
    end
    pending_results.push_back(b);
    blocks_sent++;
    @(negedge clk_i);
  endtask

  task automatic gap();
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
  endtask

  function automatic logic [63:0] pick_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return Ones;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("aes128_cbc_ecb_block_engine test failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", result_high_o, '0);
      end else begin
        if (result_high_o !== pending_results[0].hi)
          report_mismatch("result_high", result_high_o, pending_results[0].hi);
        if (result_low_o !== pending_results[0].lo)
          report_mismatch("result_low", result_low_o, pending_results[0].lo);
        void'(pending_results.pop_front());
      end
      results_seen++;
    end
  end

  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_ready_i = 1'b0;
        hold_left--;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_ready_i = 1'b0;
        repeat ($urandom_range(1, 8) - 1) @(negedge clk_i);
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  initial begin
    logic [7:0] inv;
    int         len;
    for (int i = 0; i < 256; i++) begin
      inv = gf_inv(8'(i));
      sub_tab[i] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^
                   {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
    end
    for (int i = 0; i < 256; i++) inv_tab[sub_tab[i]] = 8'(i);
    key_hi = '0;
    key_lo = '0;
    iv_hi = '0;
    iv_lo = '0;
    chain_hi = '0;
    chain_lo = '0;
    enc_mode = 1'b1;
    cbc_mode = 1'b0;
    load_key();

    plan.push_back('{ROW_BLK, 3'd0, '0, '0, 1'b0, 1'b1,
                     64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e});
    plan.push_back('{ROW_BLK, 3'd0, Ones, Ones, 1'b1, 1'b0, '0, '0});
    plan.push_back('{ROW_CFG, REG_KEY_HIGH, 64'h0001020304050607, '0, 1'b0, 1'b0, '0, '0});
    plan.push_back('{ROW_CFG, REG_KEY_LOW, 64'h08090a0b0c0d0e0f, '0, 1'b0, 1'b0, '0, '0});
    plan.push_back('{ROW_BLK, 3'd0, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0, 1'b1,
                     64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a});
    plan.push_back('{ROW_CFG, REG_ENCRYPT, '0, '0, 1'b0, 1'b0, '0, '0});
    plan.push_back('{ROW_BLK, 3'd0, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1'b0, 1'b1,
                     64'h0011223344556677, 64'h8899aabbccddeeff});
    plan.push_back('{ROW_BLK, 3'd0, Ones, '0, 1'b0, 1'b0, '0, '0});
    plan.push_back('{ROW_CFG, REG_CHAIN, 64'h1, '0, 1'b0, 1'b0, '0, '0});
    plan.push_back('{ROW_BLK, 3'd0, Ones, Ones, 1'b0, 1'b0, '0, '0});
    plan.push_back('{ROW_BLK, 3'd0, '0, Ones, 1'b0, 1'b0, '0, '0});
    plan.push_back('{ROW_CFG, REG_IV_HIGH, Ones, '0, 1'b0, 1'b0, '0, '0});
    plan.push_back('{ROW_CFG, REG_IV_LOW, 64'h0123456789abcdef, '0, 1'b0, 1'b0, '0, '0});
    plan.push_back('{ROW_BLK, 3'd0, 64'h1111, 64'h2222, 1'b1, 1'b0, '0, '0});
    plan.push_back('{ROW_CFG, REG_ENCRYPT, 64'h1, '0, 1'b0, 1'b0, '0, '0});
    plan.push_back('{ROW_BLK, 3'd0, '0, '0, 1'b1, 1'b0, '0, '0});
    plan.push_back('{ROW_BLK, 3'd0, Ones, Ones, 1'b0, 1'b0, '0, '0});
    plan.push_back('{ROW_BLK, 3'd0, 64'h8000000000000001, '0, 1'b0, 1'b0, '0, '0});
    plan.push_back('{ROW_CFG, REG_ENCRYPT, 64'hfffffffffffffffe, '0, 1'b0, 1'b0, '0, '0});
    plan.push_back('{ROW_CFG, RegSpare, Ones, '0, 1'b0, 1'b0, '0, '0});
    plan.push_back('{ROW_CFG, RegTop, Ones, '0, 1'b0, 1'b0, '0, '0});
    plan.push_back('{ROW_BLK, 3'd0, 64'h5a5a5a5a5a5a5a5a, Ones, 1'b0, 1'b0, '0, '0});
    plan.push_back('{ROW_CFG, REG_KEY_HIGH, Ones, '0, 1'b0, 1'b0, '0, '0});
    plan.push_back('{ROW_CFG, REG_KEY_LOW, Ones, '0, 1'b0, 1'b0, '0, '0});
    plan.push_back('{ROW_CFG, REG_CHAIN, 64'h2, '0, 1'b0, 1'b0, '0, '0});
    plan.push_back('{ROW_BLK, 3'd0, '0, 64'h1, 1'b1, 1'b0, '0, '0});
    plan.push_back('{ROW_BLK, 3'd0, Ones, Ones, 1'b0, 1'b0, '0, '0});

    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        drain();
        write_reg(plan[i].idx, plan[i].hi);
      end else begin
        gap();
        send_block(plan[i].hi, plan[i].lo, plan[i].start, plan[i].typed,
                   plan[i].exp_hi, plan[i].exp_lo);
      end
    end

    for (int ph = 0; ph < 12; ph++) begin
      drain();
      calm = (ph == 11);
      for (logic [2:0] r = REG_KEY_HIGH; r <= REG_IV_LOW; r++) begin
        if ($urandom_range(0, 1) == 0) write_reg(r, pick_word());
      end
      write_reg(REG_ENCRYPT, {$urandom, $urandom_range(0, 1) == 0 ? 32'(ph % 2) : $urandom});
      write_reg(REG_CHAIN, {$urandom, ph % 4 < 2 ? 32'(1) : 32'($urandom_range(0, 1))});
      if ($urandom_range(0, 3) == 0) write_reg(RegSpare + 3'($urandom_range(0, 1)), pick_word());
      if (ph == 4) hold_left = 300;
      len = 0;
      for (int n = 0; n < 40; n++) begin
        gap();
        if ($urandom_range(0, 9) == 0) begin
          send_block(pick_word(), pick_word(), 1'($urandom), 1'b0, '0, '0);
        end else begin
          if (len == 0) len = $urandom_range(1, 6);
          send_block(pick_word(), pick_word(), len == 6 || n == 0, 1'b0, '0, '0);
          len--;
        end
      end
    end

    drain();
    repeat (20) @(negedge clk_i);
    $display("%0d blocks sent, %0d results checked, over ECB and CBC in both directions",
             blocks_sent, results_seen);
    $display("with key, IV and mode rewrites, a long receiver stall and stalls on both sides");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("aes128_cbc_ecb_block_engine test passed");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_results.size());
      $display("aes128_cbc_ecb_block_engine test failed");
    end
    $finish;
  end

endmodule
